/* sv/bed_pkg.sv */
// ----------------------------------------------------------------------------
// Byte escape decoder package
// Shared word types, decoder state codes and character lookup functions.
// ----------------------------------------------------------------------------
package bed_pkg;

  // One source character of a literal body.
  typedef struct packed {
    logic [7:0] in_char;
    logic       raw;
    logic       in_last;
  } in_data_t;

  // One decoded result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       bad_escape;
    logic       out_last;
  } out_data_t;

  // Decoder mode; code 7 is unused and behaves as idle.
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_OCT1 = 3'd2,
    MODE_OCT2 = 3'd3,
    MODE_HEX0 = 3'd4,
    MODE_HEX1 = 3'd5,
    MODE_DROP = 3'd6
  } mode_e;

  // Up to two result words produced by one character.
  typedef struct packed {
    logic [1:0] n;
    out_data_t  r0;
    out_data_t  r1;
  } push_t;

  localparam int unsigned FIFO_DEPTH = 3;

  localparam logic [7:0] CHAR_BSL = 8'h5C;
  localparam logic [7:0] CHAR_X   = 8'h78;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_7   = 8'h37;

  // Simple escape lookup: bit 8 set on a hit, low byte is the control code.
  function automatic logic [8:0] esc_lookup(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      8'h61:    r = {1'b1, 8'd7};   // a
      8'h62:    r = {1'b1, 8'd8};   // b
      8'h66:    r = {1'b1, 8'd12};  // f
      8'h6E:    r = {1'b1, 8'd10};  // n
      8'h72:    r = {1'b1, 8'd13};  // r
      8'h74:    r = {1'b1, 8'd9};   // t
      8'h76:    r = {1'b1, 8'd11};  // v
      CHAR_BSL: r = {1'b1, CHAR_BSL};
      default:  r = 9'd0;
    endcase
    return r;
  endfunction

  // Hex digit value; bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = 5'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = 5'(c - 8'h61 + 8'd10);
    end
    return r;
  endfunction

endpackage

/* sv/bed_in_stage.sv */
// ----------------------------------------------------------------------------
// Byte escape decoder input stage
// Registers one incoming character word and holds it until it is decoded.
// ----------------------------------------------------------------------------
module bed_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bed_pkg::in_data_t in_data_i,
  input  logic              fire_i,
  output logic              valid_o,
  output bed_pkg::in_data_t data_o
);
  import bed_pkg::*;

  logic     valid_q, valid_d;
  in_data_t data_q;
  logic     load;

  // The register can take a new word when empty or when its word leaves now.
  assign in_ready_o = !valid_q || fire_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !fire_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/bed_decode.sv */
// ----------------------------------------------------------------------------
// Byte escape decoder core
// Holds the escape mode and digit accumulator and turns one character into
// zero, one or two result words.
// ----------------------------------------------------------------------------
module bed_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  bed_pkg::in_data_t data_i,
  output bed_pkg::push_t    push_o
);
  import bed_pkg::*;

  mode_e      mode_q, mode_d;
  logic [8:0] accum_q, accum_d;
  push_t      res;
  logic [7:0] c;
  logic       is_oct;
  logic [8:0] esc;
  logic [4:0] hex;
  logic [8:0] oct_acc;
  logic       err;
  logic       skip_last;

  assign c       = data_i.in_char;
  assign is_oct  = (c >= CHAR_0) && (c <= CHAR_7);
  assign esc     = esc_lookup(c);
  assign hex     = hex_value(c);
  assign oct_acc = {accum_q[5:0], c[2:0]};

  // Next mode, accumulator and result words for the held character.
  always_comb begin
    mode_d    = mode_q;
    accum_d   = accum_q;
    res       = '0;
    err       = 1'b0;
    skip_last = 1'b0;

    if (mode_q == MODE_DROP) begin
      // Everything up to the end of the literal is discarded.
      skip_last = 1'b1;
      if (data_i.in_last) begin
        mode_d = MODE_IDLE;
      end
    end else if (data_i.raw) begin
      res.n          = 2'd1;
      res.r0.out_byte = c;
      mode_d         = MODE_IDLE;
      accum_d        = 9'd0;
    end else begin
      unique case (mode_q)
        MODE_ESC: begin
          if (esc[8]) begin
            res.n           = 2'd1;
            res.r0.out_byte = esc[7:0];
            mode_d          = MODE_IDLE;
          end else if (is_oct) begin
            accum_d = {6'd0, c[2:0]};
            mode_d  = MODE_OCT1;
            if (data_i.in_last) begin
              res.n           = 2'd1;
              res.r0.out_byte = {5'd0, c[2:0]};
              mode_d          = MODE_IDLE;
            end
          end else if (c == CHAR_X) begin
            if (data_i.in_last) begin
              err = 1'b1;
            end else begin
              mode_d = MODE_HEX0;
            end
          end else begin
            // Unknown escape keeps both the backslash and the character.
            res.n           = 2'd2;
            res.r0.out_byte = CHAR_BSL;
            res.r1.out_byte = c;
            mode_d          = MODE_IDLE;
          end
        end
        MODE_OCT1, MODE_OCT2: begin
          if (is_oct) begin
            accum_d = oct_acc;
            if (mode_q == MODE_OCT2 || data_i.in_last) begin
              res.n           = 2'd1;
              res.r0.out_byte = oct_acc[7:0];
              mode_d          = MODE_IDLE;
            end else begin
              mode_d = MODE_OCT2;
            end
          end else begin
            // Octal ended early: emit it, then treat the character as plain.
            res.n           = 2'd1;
            res.r0.out_byte = accum_q[7:0];
            if (c == CHAR_BSL && !data_i.in_last) begin
              mode_d = MODE_ESC;
            end else begin
              res.n           = 2'd2;
              res.r1.out_byte = c;
              mode_d          = MODE_IDLE;
            end
          end
        end
        MODE_HEX0: begin
          if (hex[4] || data_i.in_last) begin
            err = 1'b1;
          end else begin
            accum_d = {5'd0, hex[3:0]};
            mode_d  = MODE_HEX1;
          end
        end
        MODE_HEX1: begin
          if (hex[4]) begin
            err = 1'b1;
          end else begin
            res.n           = 2'd1;
            res.r0.out_byte = {accum_q[3:0], hex[3:0]};
            mode_d          = MODE_IDLE;
          end
        end
        default: begin
          if (c == CHAR_BSL && !data_i.in_last) begin
            mode_d = MODE_ESC;
          end else begin
            res.n           = 2'd1;
            res.r0.out_byte = c;
            mode_d          = MODE_IDLE;
          end
        end
      endcase

      if (err) begin
        // A malformed hex escape gives one error word and drops the rest.
        skip_last          = 1'b1;
        res                = '0;
        res.n              = 2'd1;
        res.r0.bad_escape  = 1'b1;
        res.r0.out_last    = 1'b1;
        accum_d            = 9'd0;
        mode_d             = data_i.in_last ? MODE_IDLE : MODE_DROP;
      end
    end

    // The end of the literal resets the state and marks its last word.
    if (data_i.in_last && !skip_last) begin
      mode_d  = MODE_IDLE;
      accum_d = 9'd0;
      if (res.n == 2'd2) begin
        res.r1.out_last = 1'b1;
      end else if (res.n == 2'd1) begin
        res.r0.out_last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      accum_q <= 9'd0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      accum_q <= accum_d;
    end
  end

  // Result words are only pushed when the character is consumed.
  always_comb begin
    push_o = res;
    if (!fire_i) begin
      push_o.n = 2'd0;
    end
  end

endmodule

/* sv/bed_out_fifo.sv */
// ----------------------------------------------------------------------------
// Byte escape decoder output queue
// Three-entry result register queue that takes up to two words per cycle
// and presents one word per cycle on the output channel while out_ready_i is high.
// ----------------------------------------------------------------------------
module bed_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bed_pkg::push_t     push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bed_pkg::out_data_t out_data_o
);
  import bed_pkg::*;

  localparam logic [1:0] LAST_PTR = 2'(FIFO_DEPTH - 1);

  out_data_t  mem_q [FIFO_DEPTH];
  logic [1:0] count_q, count_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] wr_ptr_p1;
  logic       pop;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == LAST_PTR) ? 2'd0 : p + 2'd1;
  endfunction

  // Room for a full pair of words, independent of the output side.
  assign room_o      = (count_q <= 2'd1);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_p1 = ptr_inc(wr_ptr_q);
    count_d   = count_q - {1'b0, pop} + push_i.n;
    rd_ptr_d  = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    case (push_i.n)
      2'd1:    wr_ptr_d = wr_ptr_p1;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_p1);
      default: wr_ptr_d = wr_ptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      rd_ptr_q <= 2'd0;
      wr_ptr_q <= 2'd0;
    end else begin
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
    end
  end

  // Result word storage.
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_p1] <= push_i.r1;
    end
  end

`ifndef SYNTHESIS
  // A push never overfills the queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_q} + {1'b0, push_i.n}) <= 3'(FIFO_DEPTH))
    else $error("output queue overflow");

  // An error word is always zero and closes the literal.
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_escape |->
      out_data_o.out_last && (out_data_o.out_byte == 8'd0))
    else $error("malformed error word");

  // From empty, at most two words can arrive in one cycle.
  a_empty_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd0 |=> count_q <= 2'd2)
    else $error("fill count jumped from empty");
`endif

endmodule

/* sv/bytes_escape_decoder.sv */
// ----------------------------------------------------------------------------
// Byte-literal escape decoder
// Decodes a byte-string literal body one character per word, resolving
// simple, octal and hex escapes and flagging malformed hex escapes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_char, raw, in_last
//  out     | output    | out_valid_o / out_ready_i| out_byte, bad_escape,
//          |           |                          | out_last
//
// One character is decoded per cycle while the output queue has room; a
// character that yields two bytes places two words on the output channel.
// A character passes through the input register, then the output queue.
// The input side stalls only while the three-entry output queue holds two
// or more words; in_ready_o does not depend on out_ready_i.
// Reset clears the escape mode, the digit accumulator and both valid paths.
// ----------------------------------------------------------------------------
module bytes_escape_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bed_pkg::in_data_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bed_pkg::out_data_t out_data_o
);
  import bed_pkg::*;

  logic     held_valid;
  in_data_t held_data;
  logic     room;
  logic     fire;
  push_t    push;

  // A held character is decoded when the queue has room for two words.
  assign fire = held_valid && room;

  bed_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .fire_i     (fire),
    .valid_o    (held_valid),
    .data_o     (held_data)
  );

  bed_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .data_i (held_data),
    .push_o (push)
  );

  bed_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* sim/bytes_escape_decoder_test.sv */
// ----------------------------------------------------------------------------
// Byte-literal escape decoder testbench
// Sends literal bodies through the decoder, one character per word, and
// checks every decoded word against a local model of the escape decoding.
// A short directed part covers the escape forms and their corner cases.
// Random literals with idle and stall gaps on both channels follow.
// ----------------------------------------------------------------------------
module bytes_escape_decoder_test;
  import bed_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned PHASE_WORDS = 160;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_data_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_data_t out_data_o;

  bytes_escape_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Characters waiting to be sent and decoded bytes waiting to arrive.
  in_data_t  char_queue[$];
  out_data_t expected_bytes[$];

  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 71;
  int unsigned chars_queued = 0;
  int unsigned error_count = 0;
  int unsigned word_count = 0;
  int unsigned cycle_count = 0;

  // Decoder state as seen by the model.
  mode_e      dec_mode = MODE_IDLE;
  logic [8:0] dec_accum = '0;
  out_data_t  step_bytes[2];
  int         step_count;

  // Clock with a period of two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Value of a hex digit; bit 4 flags a character that is not one.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b0, c[3:0]};
    end
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      return {1'b0, c[3:0] + 4'd9};
    end
    return 5'h10;
  endfunction

  // Control code of a simple escape; bit 8 flags a known escape letter.
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    case (c)
      8'h61:    return {1'b1, 8'd7};   // a
      8'h62:    return {1'b1, 8'd8};   // b
      8'h66:    return {1'b1, 8'd12};  // f
      8'h6E:    return {1'b1, 8'd10};  // n
      8'h72:    return {1'b1, 8'd13};  // r
      8'h74:    return {1'b1, 8'd9};   // t
      8'h76:    return {1'b1, 8'd11};  // v
      CHAR_BSL: return {1'b1, CHAR_BSL};
      default:  return 9'd0;
    endcase
  endfunction

  function automatic bit is_octal(input logic [7:0] c);
    return c >= CHAR_0 && c <= CHAR_7;
  endfunction

  // Collects one decoded byte of the current character, at most two.
  function automatic void add_byte(input logic [7:0] b);
    if (step_count < 2) begin
      step_bytes[step_count] = '{out_byte: b, bad_escape: 1'b0, out_last: 1'b0};
      step_count++;
    end
  endfunction

  // A character outside any escape: a backslash opens one unless it is last.
  function automatic void take_plain(input logic [7:0] c, input logic last);
    if (c == CHAR_BSL && !last) begin
      dec_mode = MODE_ESC;
    end else begin
      add_byte(c);
      dec_mode = MODE_IDLE;
    end
  endfunction

  // A malformed hex escape gives one error word and drops the rest.
  function automatic void flag_bad_hex(input logic last);
    expected_bytes.push_back('{out_byte: 8'd0, bad_escape: 1'b1, out_last: 1'b1});
    dec_accum = '0;
    dec_mode = last ? MODE_IDLE : MODE_DROP;
  endfunction

  // Advances the model by one accepted character and queues its bytes.
  function automatic void decode_char(input in_data_t w);
    logic [8:0] code;
    logic [4:0] hv;
    logic [7:0] c;
    c = w.in_char;
    code = simple_escape(c);
    hv = hex_digit(c);
    step_count = 0;
    if (dec_mode == MODE_DROP) begin
      if (w.in_last) begin
        dec_mode = MODE_IDLE;
      end
      return;
    end
    if (w.raw) begin
      add_byte(c);
      dec_mode = MODE_IDLE;
      dec_accum = '0;
    end else begin
      case (dec_mode)
        MODE_ESC: begin
          if (code[8]) begin
            add_byte(code[7:0]);
            dec_mode = MODE_IDLE;
          end else if (is_octal(c)) begin
            dec_accum = {6'd0, c[2:0]};
            dec_mode = MODE_OCT1;
            if (w.in_last) begin
              add_byte(dec_accum[7:0]);
              dec_mode = MODE_IDLE;
            end
          end else if (c == CHAR_X) begin
            if (w.in_last) begin
              flag_bad_hex(1'b1);
              return;
            end
            dec_mode = MODE_HEX0;
          end else begin
            add_byte(CHAR_BSL);
            add_byte(c);
            dec_mode = MODE_IDLE;
          end
        end
        MODE_OCT1, MODE_OCT2: begin
          if (is_octal(c)) begin
            dec_accum = {dec_accum[5:0], c[2:0]};
            if (dec_mode == MODE_OCT2 || w.in_last) begin
              add_byte(dec_accum[7:0]);
              dec_mode = MODE_IDLE;
            end else begin
              dec_mode = MODE_OCT2;
            end
          end else begin
            // Octal escape cut short: emit it, then treat the character as plain.
            add_byte(dec_accum[7:0]);
            take_plain(c, w.in_last);
          end
        end
        MODE_HEX0: begin
          if (hv[4] || w.in_last) begin
            flag_bad_hex(w.in_last);
            return;
          end
          dec_accum = {5'd0, hv[3:0]};
          dec_mode = MODE_HEX1;
        end
        MODE_HEX1: begin
          if (hv[4]) begin
            flag_bad_hex(w.in_last);
            return;
          end
          add_byte({dec_accum[3:0], hv[3:0]});
          dec_mode = MODE_IDLE;
        end
        default: begin
          take_plain(c, w.in_last);
        end
      endcase
    end
    if (w.in_last) begin
      dec_mode = MODE_IDLE;
      dec_accum = '0;
      if (step_count > 0) begin
        step_bytes[step_count - 1].out_last = 1'b1;
      end
    end
    for (int k = 0; k < step_count; k++) begin
      expected_bytes.push_back(step_bytes[k]);
    end
  endfunction

  // Driver: offers the next queued character, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_char(in_data_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (char_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= char_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls at random and checks each decoded word in order.
  always @(posedge clk_i or negedge rst_ni) begin
    out_data_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        word_count++;
        if (expected_bytes.size() == 0) begin
          error_count++;
          $display("%0t: word %0d expected none, got byte %02h bad %b last %b", $time,
                   word_count, out_data_o.out_byte, out_data_o.bad_escape,
                   out_data_o.out_last);
        end else begin
          want = expected_bytes.pop_front();
          if (out_data_o.out_byte !== want.out_byte ||
              out_data_o.bad_escape !== want.bad_escape ||
              out_data_o.out_last !== want.out_last) begin
            error_count++;
            $display("%0t: word %0d expected %02h/%b/%b, got %02h/%b/%b",
                     $time, word_count, want.out_byte, want.bad_escape, want.out_last,
                     out_data_o.out_byte, out_data_o.bad_escape, out_data_o.out_last);
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bytes_escape_decoder: mismatch");
      $finish;
    end
  end

  task automatic put_char(input logic [7:0] c, input logic raw);
    char_queue.push_back('{in_char: c, raw: raw, in_last: 1'b0});
    chars_queued++;
  endtask

  // Marks the most recently queued character as the end of its literal.
  task automatic close_literal();
    in_data_t w;
    w = char_queue.pop_back();
    w.in_last = 1'b1;
    char_queue.push_back(w);
  endtask

  function automatic logic [7:0] rand_hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 4'd10) begin
      return CHAR_0 + 8'(v);
    end
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    logic [4:0] hv;
    do begin
      c = 8'($urandom_range(0, 255));
      hv = hex_digit(c);
    end while (!hv[4]);
    return c;
  endfunction

  function automatic logic [7:0] rand_unknown_escape();
    logic [7:0] c;
    logic [8:0] code;
    do begin
      c = 8'($urandom_range(0, 255));
      code = simple_escape(c);
    end while (code[8] || is_octal(c) || c == CHAR_X);
    return c;
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CHAR_BSL);
    return c;
  endfunction

  // One random literal: mostly well-formed escapes, some noise.
  task automatic gen_literal();
    int unsigned pieces;
    int unsigned digits;
    logic [8:0] code;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        put_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end else begin
      pieces = $urandom_range(1, 6);
      repeat (pieces) begin
        case ($urandom_range(0, 9))
          0, 9: put_char(rand_plain(), 1'b0);
          1: begin
            do begin
              code = simple_escape(8'($urandom_range(0, 255)));
            end while (!code[8]);
            // Any byte whose code hits is the escape letter itself.
            put_char(CHAR_BSL, 1'b0);
            case ($urandom_range(0, 7))
              0: put_char(8'h61, 1'b0);
              1: put_char(8'h62, 1'b0);
              2: put_char(8'h66, 1'b0);
              3: put_char(8'h6E, 1'b0);
              4: put_char(8'h72, 1'b0);
              5: put_char(8'h74, 1'b0);
              6: put_char(8'h76, 1'b0);
              default: put_char(CHAR_BSL, 1'b0);
            endcase
          end
          2: begin
            put_char(CHAR_BSL, 1'b0);
            digits = $urandom_range(1, 3);
            repeat (digits) put_char(CHAR_0 + 8'($urandom_range(0, 7)), 1'b0);
          end
          3: begin
            put_char(CHAR_BSL, 1'b0);
            put_char(CHAR_X, 1'b0);
            put_char(rand_hex_char(), 1'b0);
            put_char(rand_hex_char(), 1'b0);
          end
          4: begin
            // Malformed hex escape; whatever follows is dropped.
            put_char(CHAR_BSL, 1'b0);
            put_char(CHAR_X, 1'b0);
            if ($urandom_range(0, 1)) put_char(rand_hex_char(), 1'b0);
            put_char(rand_non_hex(), 1'b0);
          end
          5: begin
            put_char(CHAR_BSL, 1'b0);
            put_char(rand_unknown_escape(), 1'b0);
          end
          6: put_char(8'($urandom_range(0, 255)), 1'b1);
          default: begin
            put_char(CHAR_BSL, 1'b0);
            put_char(8'($urandom_range(0, 255)), 1'b1);
          end
        endcase
      end
      // Sometimes the literal ends in the middle of an escape.
      case ($urandom_range(0, 7))
        0: put_char(CHAR_BSL, 1'b0);
        1: begin
          put_char(CHAR_BSL, 1'b0);
          put_char(CHAR_X, 1'b0);
        end
        2: begin
          put_char(CHAR_BSL, 1'b0);
          put_char(CHAR_0 + 8'($urandom_range(0, 7)), 1'b0);
        end
        default: ;
      endcase
    end
    close_literal();
  endtask

  task automatic wait_drained();
    while (char_queue.size() != 0 || in_valid_i || expected_bytes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Newline escape, three-digit octal overflowing a byte, octal cut short
    // by a plain character, and a lone backslash at the end.
    put_char(CHAR_BSL, 1'b0);
    put_char(8'h6E, 1'b0);
    put_char(CHAR_BSL, 1'b0);
    put_char(CHAR_7, 1'b0);
    put_char(CHAR_7, 1'b0);
    put_char(CHAR_7, 1'b0);
    put_char(CHAR_BSL, 1'b0);
    put_char(8'h31, 1'b0);
    put_char(8'h7A, 1'b0);
    put_char(CHAR_BSL, 1'b0);
    close_literal();
    // Hex escape, unknown escape, raw character discarding a pending escape.
    put_char(CHAR_BSL, 1'b0);
    put_char(CHAR_X, 1'b0);
    put_char(8'h41, 1'b0);
    put_char(8'h66, 1'b0);
    put_char(CHAR_BSL, 1'b0);
    put_char(8'h71, 1'b0);
    put_char(CHAR_BSL, 1'b0);
    put_char(8'hFF, 1'b1);
    close_literal();
    // Malformed hex escape; a raw character and a zero byte are dropped.
    put_char(CHAR_BSL, 1'b0);
    put_char(CHAR_X, 1'b0);
    put_char(8'h67, 1'b0);
    put_char(8'h6B, 1'b1);
    put_char(8'h00, 1'b0);
    close_literal();
    // Hex escape cut off by the end of the literal.
    put_char(CHAR_BSL, 1'b0);
    put_char(CHAR_X, 1'b0);
    close_literal();

    // Hold the sender until every decoded word is back.
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (chars_queued < 25 + PHASE_WORDS * (phase + 1)) begin
        gen_literal();
      end
      while (char_queue.size() != 0) @(posedge clk_i);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("bytes_escape_decoder: match");
    end else begin
      $display("bytes_escape_decoder: mismatch");
    end
    $finish;
  end

endmodule
